FILE: rtl/core/pinhole_primary_ray_generator_unit_macros.svh
// Assertion macros used by the ray generator unit.
`ifndef PINHOLE_PRIMARY_RAY_GENERATOR_UNIT_MACROS_SVH
`define PINHOLE_PRIMARY_RAY_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define PPRG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pprg assertion failed");
`define PPRG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pprg assertion failed");
`else
`define PPRG_ASSERT(lbl, prop)
`define PPRG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/pprg_pkg.sv
// Shared types and constants of the pinhole ray generator.
`default_nettype none
package pprg_pkg;

    localparam int WIDTH_BITS     = 13;
    localparam int SCALE_BITS     = 16;
    localparam int SCALE_FRAC     = 12;
    localparam int SCALE_ROUND    = 2048;
    localparam int ENTRY_BITS     = 16;
    localparam int REG_BITS       = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int DIR_BITS       = 16;
    localparam int NORM_BITS      = 30;
    localparam int NORM_TOP       = 29;

    localparam logic [WIDTH_BITS-1:0] RST_WIDTH   = 13'd640;
    localparam logic [WIDTH_BITS-1:0] RST_HEIGHT  = 13'd480;
    localparam logic [SCALE_BITS-1:0] RST_SCALE   = 16'd4096;
    localparam logic [REG_BITS-1:0]   RST_ROW0    = 48'h0000_0000_4000;
    localparam logic [REG_BITS-1:0]   RST_ROW1    = 48'h0000_4000_0000;
    localparam logic [REG_BITS-1:0]   RST_ROW2    = 48'h4000_0000_0000;
    localparam logic [REG_BITS-1:0]   RST_ORIGIN  = 48'h0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_SCALE_H      = 3'd2,
        CFG_SCALE_V      = 3'd3,
        CFG_ROW0         = 3'd4,
        CFG_ROW1         = 3'd5,
        CFG_ROW2         = 3'd6,
        CFG_ORIGIN       = 3'd7
    } t_cfg_index;

    // normalized magnitudes, signs, zero flag; carried with the root
    typedef struct packed {
        logic                           zero;
        logic [2:0]                     neg;
        logic [2:0][NORM_BITS-1:0]      mag;
    } t_norm_tag;

endpackage
`default_nettype wire

FILE: rtl/core/pprg_udiv.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pprg_udiv #(
    parameter int DW = 14,
    parameter int QW = 29,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [TW-1:0] r_tag [0:QW-1];
    logic [DW-1:0] n_rem [0:QW-1];
    logic [QW-1:0] n_low [0:QW-1];
    logic [QW-1:0] r_valid;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_low;
        logic [DW:0]   trial;
        logic          ge;
        if (k == 0) begin : g_first
            assign src_rem = i_rem;
            assign src_low = i_low;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_low = r_low[k-1];
        end
        // bring down the next numerator bit, quotient bit enters at the bottom
        assign trial    = {src_rem, src_low[QW-1]};
        assign ge       = trial >= {1'b0, ((k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1])};
        assign n_rem[k] = ge ? DW'(trial - {1'b0, ((k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1])})
                             : trial[DW-1:0];
        assign n_low[k] = {src_low[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
                r_tag[k] <= (k == 0) ? i_tag : r_tag[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QW-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_low[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule
`default_nettype wire

FILE: rtl/core/pprg_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module pprg_isqrt #(
    parameter int LW = 62,
    parameter int TW = 94
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [LW-1:0]   i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic            o_valid,
    output logic [LW/2-1:0] o_root,
    output logic [TW-1:0]   o_tag
);

    localparam int RW = LW / 2;

    logic [RW:0]   r_rem  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];
    logic [LW-1:0] r_rad  [0:RW-1];
    logic [TW-1:0] r_tag  [0:RW-1];
    logic [RW:0]   n_rem  [0:RW-1];
    logic [RW-1:0] n_root [0:RW-1];
    logic [RW-1:0] r_valid;

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RW:0]   src_rem;
        logic [RW-1:0] src_root;
        logic [LW-1:0] src_rad;
        logic [RW+2:0] t;
        logic [RW+2:0] trial;
        logic          ge;
        if (k == 0) begin : g_first
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_rad  = i_rad;
        end else begin : g_next
            assign src_rem  = r_rem[k-1];
            assign src_root = r_root[k-1];
            assign src_rad  = r_rad[k-1];
        end
        // bring down two radicand bits, try root*4+1
        assign t         = {src_rem, src_rad[LW-1:LW-2]};
        assign trial     = {1'b0, src_root, 2'b01};
        assign ge        = t >= trial;
        assign n_rem[k]  = ge ? (RW+1)'(t - trial) : t[RW:0];
        assign n_root[k] = {src_root[RW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= ((k == 0) ? i_rad : r_rad[(k == 0) ? 0 : k-1]) << 2;
                r_tag[k]  <= (k == 0) ? i_tag : r_tag[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[RW-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule
`default_nettype wire

FILE: rtl/core/pinhole_primary_ray_generator_unit.sv
// Pinhole camera primary ray generator: pixel in, unit direction and origin out.
//
// Slave stream: one item per pixel, tdata = pixel_x, pixel_y (COORD_BITS each).
// Master stream: one ray per pixel, tdata = dir_x, dir_y, dir_z (Q1.FRAC_BITS),
// origin_x, origin_y, origin_z (Q8.8), lowest field first.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high,
// only while no item is in flight; origin is shown straight from its register.
// Throughput: one item per cycle while the skid is empty; stages advance together.
// Pipeline from accept to tvalid: the screen divider (COORD_BITS+FRAC_BITS+3
// stages), nine arithmetic stages, the root (31 stages), the unit divider
// (FRAC_BITS+1 stages) and the output register.
// Reset clears all valid bits, holds tready low and loads the default camera registers.
// A stalled receiver fills the output register and then a one-item skid stage;
// tready drops only once the skid stage is full, and nothing in flight is lost.
`default_nettype none
`include "pinhole_primary_ray_generator_unit_macros.svh"
module pinhole_primary_ray_generator_unit import pprg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]          i_cfg_index,
    input  logic [REG_BITS-1:0]                i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // pixel_x, pixel_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // dir_x, dir_y, dir_z, origin_x, origin_y, origin_z
    output logic [6*DIR_BITS-1:0]              o_m_tdata
);

    localparam int FNW  = COORD_BITS + FRAC_BITS + 3;
    localparam int FDW  = WIDTH_BITS + 1;
    localparam int UW   = COORD_BITS + FRAC_BITS + 2;
    localparam int SMW  = UW + SCALE_BITS - SCALE_FRAC;
    localparam int SW   = SMW + 1;
    localparam int PW   = SW + ENTRY_BITS;
    localparam int DDW  = PW + 2;
    localparam int MW   = DDW;
    localparam int PBW  = $clog2(MW);
    localparam int LW   = 2 * NORM_BITS + 2;
    localparam int RW   = LW / 2;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NUMW = NORM_BITS + FRAC_BITS + 1;
    localparam int TAGW = $bits(t_norm_tag);

    localparam logic [FNW:0]   ONE_EXT = (FNW+1)'(1) << FRAC_BITS;
    localparam logic [QW-1:0]  ONE_Q   = QW'(1) << FRAC_BITS;
    localparam logic [PBW-1:0] TOP_P   = PBW'(NORM_TOP);
    localparam logic [SW-1:0]  S_Z     = SW'(0) - (SW'(1) << FRAC_BITS);

    // configuration registers
    logic [WIDTH_BITS-1:0] r_width, r_height;
    logic [SCALE_BITS-1:0] r_scale_h, r_scale_v;
    logic [REG_BITS-1:0]   r_row [0:2];
    logic [REG_BITS-1:0]   r_origin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_scale_h <= RST_SCALE;
            r_scale_v <= RST_SCALE;
            r_row[0]  <= RST_ROW0;
            r_row[1]  <= RST_ROW1;
            r_row[2]  <= RST_ROW2;
            r_origin  <= RST_ORIGIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_width   <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_SCALE_H:      r_scale_h <= i_cfg_data[SCALE_BITS-1:0];
                CFG_SCALE_V:      r_scale_v <= i_cfg_data[SCALE_BITS-1:0];
                CFG_ROW0:         r_row[0]  <= i_cfg_data;
                CFG_ROW1:         r_row[1]  <= i_cfg_data;
                CFG_ROW2:         r_row[2]  <= i_cfg_data;
                CFG_ORIGIN:       r_origin  <= i_cfg_data;
                default:          r_row[0]  <= r_row[0];
            endcase
        end
    end

    // output register and skid stage
    logic                         r_ovalid, r_svalid;
    logic [2:0][DIR_BITS-1:0]     r_odir, r_sdir;
    logic                         w_adv;

    assign w_adv      = !r_svalid;
    assign o_s_tready = w_adv && i_rst_n;

    // screen coordinate division
    logic [COORD_BITS-1:0] w_px, w_py;
    logic [WIDTH_BITS-1:0] w_w_eff, w_h_eff;
    logic [FNW-1:0]        w_num_u, w_num_v;
    logic                  du_v;
    logic [FNW-1:0]        du_q, dv_q;

    assign w_px    = i_s_tdata[COORD_BITS-1:0];
    assign w_py    = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_w_eff = (r_width  == '0) ? WIDTH_BITS'(1) : r_width;
    assign w_h_eff = (r_height == '0) ? WIDTH_BITS'(1) : r_height;
    assign w_num_u = (FNW'({w_px, 1'b1}) << (FRAC_BITS + 1)) + FNW'(w_w_eff);
    assign w_num_v = (FNW'({w_py, 1'b1}) << (FRAC_BITS + 1)) + FNW'(w_h_eff);

    pprg_udiv #(.DW(FDW), .QW(FNW), .TW(1)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(i_s_tvalid),
        .i_rem('0), .i_low(w_num_u), .i_den({w_w_eff, 1'b0}), .i_tag(1'b0),
        .o_valid(du_v), .o_quo(du_q), .o_tag()
    );

    pprg_udiv #(.DW(FDW), .QW(FNW), .TW(1)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(i_s_tvalid),
        .i_rem('0), .i_low(w_num_v), .i_den({w_h_eff, 1'b0}), .i_tag(1'b0),
        .o_valid(), .o_quo(dv_q), .o_tag()
    );

    // stage A: center, take magnitude, multiply by scale
    logic [FNW:0]             w_u, w_v, w_u_abs, w_v_abs;
    logic                     r_a_v, r_a_nu, r_a_nv;
    logic [UW+SCALE_BITS-1:0] r_a_mu, r_a_mv;

    assign w_u     = {1'b0, du_q} - ONE_EXT;
    assign w_v     = ONE_EXT - {1'b0, dv_q};
    assign w_u_abs = w_u[FNW] ? ((FNW+1)'(0) - w_u) : w_u;
    assign w_v_abs = w_v[FNW] ? ((FNW+1)'(0) - w_v) : w_v;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_nu <= w_u[FNW];
            r_a_nv <= w_v[FNW];
            r_a_mu <= w_u_abs[UW-1:0] * r_scale_h;
            r_a_mv <= w_v_abs[UW-1:0] * r_scale_v;
        end
    end

    // stage B: round half away from zero, restore sign
    logic [UW+SCALE_BITS-1:0] w_su, w_sv;
    logic [SW-1:0]            w_su_mag, w_sv_mag;
    logic                     r_b_v;
    logic signed [SW-1:0]     r_b_s [0:1];

    assign w_su     = (r_a_mu + (UW+SCALE_BITS)'(SCALE_ROUND)) >> SCALE_FRAC;
    assign w_sv     = (r_a_mv + (UW+SCALE_BITS)'(SCALE_ROUND)) >> SCALE_FRAC;
    assign w_su_mag = {1'b0, w_su[SMW-1:0]};
    assign w_sv_mag = {1'b0, w_sv[SMW-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_s[0] <= r_a_nu ? (SW'(0) - w_su_mag) : w_su_mag;
            r_b_s[1] <= r_a_nv ? (SW'(0) - w_sv_mag) : w_sv_mag;
        end
    end

    // stage C: the nine matrix products
    logic signed [ENTRY_BITS-1:0] w_e [0:2][0:2];
    logic signed [SW-1:0]         w_s [0:2];
    logic                         r_c_v;
    logic signed [PW-1:0]         r_c_p [0:2][0:2];

    always_comb begin
        w_s[0] = r_b_s[0];
        w_s[1] = r_b_s[1];
        w_s[2] = S_Z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_e[i][j] = $signed(r_row[i][ENTRY_BITS*j +: ENTRY_BITS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_c_p[i][j] <= w_e[i][j] * w_s[j];
                end
            end
        end
    end

    // stage D: row sums
    logic                  r_d_v;
    logic signed [DDW-1:0] r_d_d [0:2];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_d_d[i] <= DDW'(r_c_p[i][0]) + DDW'(r_c_p[i][1]) + DDW'(r_c_p[i][2]);
            end
        end
    end

    // stage E: magnitudes and their maximum
    logic [MW-1:0] w_mag [0:2];
    logic [MW-1:0] w_m;
    logic          r_e_v;
    logic [2:0]    r_e_neg;
    logic [MW-1:0] r_e_mag [0:2];
    logic [MW-1:0] r_e_m;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_d_d[i][DDW-1] ? (MW'(0) - MW'(r_d_d[i])) : MW'(r_d_d[i]);
        end
        w_m = w_mag[0];
        if (w_mag[1] > w_m) w_m = w_mag[1];
        if (w_mag[2] > w_m) w_m = w_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e_neg[i] <= r_d_d[i][DDW-1];
                r_e_mag[i] <= w_mag[i];
            end
            r_e_m <= w_m;
        end
    end

    // stage F: leading one of the maximum
    logic [PBW-1:0] w_p;
    logic           r_f_v, r_f_zero;
    logic [PBW-1:0] r_f_p;
    logic [2:0]     r_f_neg;
    logic [MW-1:0]  r_f_mag [0:2];

    always_comb begin
        w_p = '0;
        for (int b = 0; b < MW; b++) begin
            if (r_e_m[b]) w_p = PBW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_p    <= w_p;
            r_f_zero <= (r_e_m == '0);
            r_f_neg  <= r_e_neg;
            for (int i = 0; i < 3; i++) r_f_mag[i] <= r_e_mag[i];
        end
    end

    // stage G: block normalize so the largest lands just below 2^30
    t_norm_tag w_g_tag;
    t_norm_tag r_g_tag;
    logic      r_g_v;

    always_comb begin
        w_g_tag.zero = r_f_zero;
        w_g_tag.neg  = r_f_neg;
        for (int i = 0; i < 3; i++) begin
            if (r_f_p >= TOP_P) begin
                w_g_tag.mag[i] = NORM_BITS'(r_f_mag[i] >> (r_f_p - TOP_P));
            end else begin
                w_g_tag.mag[i] = r_f_mag[i][NORM_BITS-1:0] << (TOP_P - r_f_p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_g_tag <= w_g_tag;
    end

    // stage H: squares
    logic                     r_h_v;
    logic [2*NORM_BITS-1:0]   r_h_sq [0:2];
    t_norm_tag                r_h_tag;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) r_h_sq[i] <= r_g_tag.mag[i] * r_g_tag.mag[i];
            r_h_tag <= r_g_tag;
        end
    end

    // stage I: squared length
    logic          r_i_v;
    logic [LW-1:0] r_i_l;
    t_norm_tag     r_i_tag;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_i_l   <= LW'(r_h_sq[0]) + LW'(r_h_sq[1]) + LW'(r_h_sq[2]);
            r_i_tag <= r_h_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= du_v;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
        end
    end

    // length
    logic          sq_v;
    logic [RW-1:0] sq_root;
    t_norm_tag     sq_tag;

    pprg_isqrt #(.LW(LW), .TW(TAGW)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_i_v),
        .i_rad(r_i_l), .i_tag(r_i_tag),
        .o_valid(sq_v), .o_root(sq_root), .o_tag(sq_tag)
    );

    // unit vector: (mag * 2^F + r/2) / r per lane
    logic [NUMW-1:0] w_num  [0:2];
    logic [RW-1:0]   w_drem [0:2];
    logic [QW-1:0]   w_dlow [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i]  = (NUMW'(sq_tag.mag[i]) << FRAC_BITS) + NUMW'(sq_root >> 1);
            w_drem[i] = RW'(w_num[i][NUMW-1:QW]);
            w_dlow[i] = w_num[i][QW-1:0];
        end
    end

    logic          dq_v;
    logic [QW-1:0] dq [0:2];
    logic [1:0]    dq_tag0;
    logic          dq_neg1, dq_neg2;

    pprg_udiv #(.DW(RW), .QW(QW), .TW(2)) u_unit_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(sq_v),
        .i_rem(w_drem[0]), .i_low(w_dlow[0]), .i_den(sq_root),
        .i_tag({sq_tag.zero, sq_tag.neg[0]}),
        .o_valid(dq_v), .o_quo(dq[0]), .o_tag(dq_tag0)
    );

    pprg_udiv #(.DW(RW), .QW(QW), .TW(1)) u_unit_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(sq_v),
        .i_rem(w_drem[1]), .i_low(w_dlow[1]), .i_den(sq_root), .i_tag(sq_tag.neg[1]),
        .o_valid(), .o_quo(dq[1]), .o_tag(dq_neg1)
    );

    pprg_udiv #(.DW(RW), .QW(QW), .TW(1)) u_unit_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(sq_v),
        .i_rem(w_drem[2]), .i_low(w_dlow[2]), .i_den(sq_root), .i_tag(sq_tag.neg[2]),
        .o_valid(), .o_quo(dq[2]), .o_tag(dq_neg2)
    );

    // clamp, sign, zero-length vector gives zero direction
    logic [2:0]               w_neg;
    logic [QW-1:0]            w_qc [0:2];
    logic signed [QW:0]       w_sd [0:2];
    logic [2:0][DIR_BITS-1:0] w_dir;
    logic                     w_take;

    assign w_neg  = {dq_neg2, dq_neg1, dq_tag0[0]};
    assign w_take = dq_v && w_adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qc[i] = (dq[i] > ONE_Q) ? ONE_Q : dq[i];
            if (dq_tag0[1]) begin
                w_sd[i] = '0;
            end else if (w_neg[i]) begin
                w_sd[i] = (QW+1)'(0) - {1'b0, w_qc[i]};
            end else begin
                w_sd[i] = {1'b0, w_qc[i]};
            end
            w_dir[i] = DIR_BITS'(w_sd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (!r_ovalid || i_m_tready) begin
            if (r_svalid) begin
                r_ovalid <= 1'b1;
                r_svalid <= 1'b0;
            end else begin
                r_ovalid <= w_take;
            end
        end else if (w_take) begin
            r_svalid <= 1'b1;
        end
    end

    // load the output register, or hold the waiting item in the skid stage on a stall
    always_ff @(posedge i_clk) begin
        if (!r_ovalid || i_m_tready) begin
            r_odir <= r_svalid ? r_sdir : w_dir;
        end else if (w_take) begin
            r_sdir <= w_dir;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_origin, r_odir};

    `PPRG_ASSERT(a_skid_needs_out, r_svalid |-> r_ovalid)
    `PPRG_ASSERT(a_norm_range, (r_g_v && !r_g_tag.zero) |-> (r_g_tag.mag[0][NORM_TOP] || r_g_tag.mag[1][NORM_TOP] || r_g_tag.mag[2][NORM_TOP]))
    `PPRG_ASSERT(a_root_bound, (sq_v && !sq_tag.zero) |-> (sq_tag.mag[0] <= sq_root && sq_tag.mag[1] <= sq_root && sq_tag.mag[2] <= sq_root))
    `PPRG_ASSERT_NEXT(a_skid_on_stall, o_m_tvalid && !i_m_tready && w_take, r_svalid)

endmodule
`default_nettype wire
